// ----- rtl/core/bln_pkg.sv -----
// ---------------------------------------------------------------------------
// bln_pkg
// Shared types and constants of the line rasterizer: register indexes,
// register widths and reset values, color and pixel attribute types.
// ---------------------------------------------------------------------------
`default_nettype none

package bln_pkg;

    // coordinate width default
    localparam int COORD_BITS_DEF = 12;

    // framebuffer address width
    localparam int ADDR_W = 32;

    // register widths
    localparam int OFS_W      = 12;
    localparam int PB_W       = 4;
    localparam int STRIDE_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [OFS_W-1:0]    X_OFFSET_RST    = '0;
    localparam logic [OFS_W-1:0]    Y_OFFSET_RST    = '0;
    localparam logic [PB_W-1:0]     PIXEL_BYTES_RST = 4'd4;
    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 16'd5464;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET    = 2'd0,
        REG_Y_OFFSET    = 2'd1,
        REG_PIXEL_BYTES = 2'd2,
        REG_LINE_STRIDE = 2'd3
    } t_cfg_reg;

    // line color
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // everything of a pixel write except its address
    typedef struct packed {
        t_rgba color;
        logic  last;
    } t_pix_attr;

    // address configuration handed to the address pipeline
    typedef struct packed {
        logic [OFS_W-1:0]    x_offset;
        logic [OFS_W-1:0]    y_offset;
        logic [PB_W-1:0]     pixel_bytes;
        logic [STRIDE_W-1:0] line_stride;
    } t_addr_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/bln_addr_pipe.sv -----
// ---------------------------------------------------------------------------
// bln_addr_pipe
// Three-stage pixel address pipeline: coordinate capture, offset add and
// multiply by pixel size and stride, final add into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bln_addr_pipe #(
    parameter int COORD_BITS = 12
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bln_pkg::t_addr_cfg      i_cfg,
    input  wire                          i_pix_valid,
    output logic                         o_pix_ready,
    input  wire [COORD_BITS-1:0]         i_pix_x,
    input  wire [COORD_BITS-1:0]         i_pix_y,
    input  wire bln_pkg::t_pix_attr      i_pix_attr,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bln_pkg::ADDR_W-1:0]   o_addr,
    output bln_pkg::t_pix_attr           o_attr
);
    import bln_pkg::*;

    localparam int SUM_W = ((COORD_BITS > OFS_W) ? COORD_BITS : OFS_W) + 1;
    localparam int COL_W = SUM_W + PB_W;
    localparam int ROW_W = SUM_W + STRIDE_W;

    // stage 1: captured coordinates
    logic                  r_v1;
    logic [COORD_BITS-1:0] r_x1;
    logic [COORD_BITS-1:0] r_y1;
    t_pix_attr             r_attr1;

    // stage 2: column and row products
    logic                  r_v2;
    logic [ADDR_W-1:0]     r_col2;
    logic [ADDR_W-1:0]     r_row2;
    t_pix_attr             r_attr2;

    // stage 3: output register
    logic                  r_v3;
    logic [ADDR_W-1:0]     r_addr3;
    t_pix_attr             r_attr3;

    logic                  rdy1;
    logic                  rdy2;
    logic                  rdy3;
    logic [SUM_W-1:0]      sum_x;
    logic [SUM_W-1:0]      sum_y;
    logic [COL_W-1:0]      col_full;
    logic [ROW_W-1:0]      row_full;

    // per-stage advance, a stage moves when the next one has room
    assign rdy3 = !r_v3 || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_pix_ready = rdy1;

    // panned coordinates and products
    assign sum_x    = SUM_W'(r_x1) + SUM_W'(i_cfg.x_offset);
    assign sum_y    = SUM_W'(r_y1) + SUM_W'(i_cfg.y_offset);
    assign col_full = COL_W'(sum_x) * COL_W'(i_cfg.pixel_bytes);
    assign row_full = ROW_W'(sum_y) * ROW_W'(i_cfg.line_stride);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_pix_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_pix_valid) begin
            r_x1    <= i_pix_x;
            r_y1    <= i_pix_y;
            r_attr1 <= i_pix_attr;
        end
        if (rdy2 && r_v1) begin
            r_col2  <= ADDR_W'(col_full);
            r_row2  <= ADDR_W'(row_full);
            r_attr2 <= r_attr1;
        end
        if (rdy3 && r_v2) begin
            r_addr3 <= r_col2 + r_row2;
            r_attr3 <= r_attr2;
        end
    end

    assign o_out_valid = r_v3;
    assign o_addr      = r_addr3;
    assign o_attr      = r_attr3;

endmodule

`default_nettype wire

// ----- rtl/core/bresenham_line_pixel_writer_core.sv -----
// Results: a step item's pixel write passes through the capture, product and
//   output registers of the address pipeline; a load item gives no result.
// Throughput: one item per cycle while the output is not stalled; each step
//   updates the line state, and the address product and sum run in a three-stage pipeline.
// Reset (synchronous, active low): no active line, pipeline empty, registers
//   back to offsets 0, 4 bytes per pixel, stride 5464.
// ---------------------------------------------------------------------------
// bresenham_line_pixel_writer_core
// Bresenham line stepper with framebuffer byte address generation.
// ---------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_writer_core #(
    parameter int COORD_BITS = bln_pkg::COORD_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire [bln_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [bln_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_action,
    input  wire [COORD_BITS-1:0]              i_x_start,
    input  wire [COORD_BITS-1:0]              i_y_start,
    input  wire [COORD_BITS-1:0]              i_x_end,
    input  wire [COORD_BITS-1:0]              i_y_end,
    input  wire [7:0]                         i_red,
    input  wire [7:0]                         i_green,
    input  wire [7:0]                         i_blue,
    input  wire [7:0]                         i_alpha,
    // result items
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [bln_pkg::ADDR_W-1:0]        o_byte_address,
    output logic [7:0]                        o_out_blue,
    output logic [7:0]                        o_out_green,
    output logic [7:0]                        o_out_red,
    output logic [7:0]                        o_out_alpha,
    output logic                              o_last_pixel
);
    import bln_pkg::*;

    localparam int ERR_W = COORD_BITS + 2;
    localparam int E2_W  = COORD_BITS + 3;

    // configuration registers
    t_addr_cfg r_cfg;

    // line state
    logic                     r_busy;
    logic [COORD_BITS-1:0]    r_cur_x;
    logic [COORD_BITS-1:0]    r_cur_y;
    logic [COORD_BITS-1:0]    r_tgt_x;
    logic [COORD_BITS-1:0]    r_tgt_y;
    logic [COORD_BITS-1:0]    r_dx;
    logic signed [COORD_BITS:0] r_ndy;
    logic                     r_sx_neg;
    logic                     r_sy_neg;
    logic signed [ERR_W-1:0]  r_err;
    t_rgba                    r_color;

    logic                     acc;
    logic                     pix_valid;
    logic                     at_end;
    logic [COORD_BITS-1:0]    ld_dx;
    logic [COORD_BITS-1:0]    ld_dy;
    logic signed [E2_W-1:0]   e2;
    logic signed [E2_W-1:0]   ndy_ext;
    logic signed [E2_W-1:0]   dx_ext;
    logic                     step_x;
    logic                     step_y;
    logic signed [E2_W-1:0]   n_err;
    logic [COORD_BITS-1:0]    n_x;
    logic [COORD_BITS-1:0]    n_y;
    t_pix_attr                pix_attr;
    t_pix_attr                out_attr;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset    <= X_OFFSET_RST;
            r_cfg.y_offset    <= Y_OFFSET_RST;
            r_cfg.pixel_bytes <= PIXEL_BYTES_RST;
            r_cfg.line_stride <= LINE_STRIDE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_X_OFFSET:    r_cfg.x_offset    <= i_cfg_data[OFS_W-1:0];
                REG_Y_OFFSET:    r_cfg.y_offset    <= i_cfg_data[OFS_W-1:0];
                REG_PIXEL_BYTES: r_cfg.pixel_bytes <= i_cfg_data[PB_W-1:0];
                REG_LINE_STRIDE: r_cfg.line_stride <= i_cfg_data[STRIDE_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // handshake, a step on an active line emits one pixel
    assign acc       = i_in_valid && o_in_ready;
    assign pix_valid = acc && i_action && r_busy;

    // load-time deltas
    assign ld_dx = (i_x_start > i_x_end) ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
    assign ld_dy = (i_y_start > i_y_end) ? (i_y_start - i_y_end) : (i_y_end - i_y_start);

    // bresenham step decision
    assign at_end  = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
    assign e2      = E2_W'(r_err) <<< 1;
    assign ndy_ext = E2_W'(r_ndy);
    assign dx_ext  = E2_W'({1'b0, r_dx});
    assign step_x  = (e2 >= ndy_ext);
    assign step_y  = (e2 <= dx_ext);
    assign n_err   = E2_W'(r_err) + (step_x ? ndy_ext : '0) + (step_y ? dx_ext : '0);
    assign n_x     = r_sx_neg ? (r_cur_x - 1'b1) : (r_cur_x + 1'b1);
    assign n_y     = r_sy_neg ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);

    // line state: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (acc) begin
            if (!i_action) begin
                r_busy <= 1'b1;
            end else if (r_busy && at_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    // line state: coordinates, deltas and error term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_ndy    <= '0;
            r_sx_neg <= 1'b0;
            r_sy_neg <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
        end else if (acc && !i_action) begin
            r_cur_x  <= i_x_start;
            r_cur_y  <= i_y_start;
            r_tgt_x  <= i_x_end;
            r_tgt_y  <= i_y_end;
            r_dx     <= ld_dx;
            r_ndy    <= -$signed({1'b0, ld_dy});
            r_sx_neg <= !(i_x_start < i_x_end);
            r_sy_neg <= !(i_y_start < i_y_end);
            r_err    <= $signed(ERR_W'(ld_dx)) - $signed(ERR_W'(ld_dy));
            r_color  <= '{red: i_red, green: i_green, blue: i_blue, alpha: i_alpha};
        end else if (pix_valid && !at_end) begin
            r_err <= ERR_W'(n_err);
            if (step_x) begin
                r_cur_x <= n_x;
            end
            if (step_y) begin
                r_cur_y <= n_y;
            end
        end
    end

    // pixel attributes of the current point
    assign pix_attr = '{color: r_color, last: at_end};

    // address pipeline and output register
    bln_addr_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_addr_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (pix_valid),
        .o_pix_ready (o_in_ready),
        .i_pix_x     (r_cur_x),
        .i_pix_y     (r_cur_y),
        .i_pix_attr  (pix_attr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_addr      (o_byte_address),
        .o_attr      (out_attr)
    );

    assign o_out_blue   = out_attr.color.blue;
    assign o_out_green  = out_attr.color.green;
    assign o_out_red    = out_attr.color.red;
    assign o_out_alpha  = out_attr.color.alpha;
    assign o_last_pixel = out_attr.last;

endmodule

`default_nettype wire

// ----- rtl/core/bln_checker.sv -----
// ---------------------------------------------------------------------------
// bln_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bln_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_ready,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [31:0] o_byte_address,
    input wire        o_last_pixel
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its address and last-pixel flag
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_byte_address) && $stable(o_last_pixel))
        else $error("result item changed while stalled");

    // with the output register empty the pipeline always has room
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind bresenham_line_pixel_writer_core bln_checker u_bln_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_byte_address (o_byte_address),
    .o_last_pixel   (o_last_pixel)
);

`default_nettype wire
